// ===== src/sgm_pkg.sv =====
package sgm_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned GRAD_W = 11;
  localparam int unsigned MAG_W  = 11;
  localparam int unsigned DIM_W  = 11;
  localparam int unsigned POS_W  = 10;
  localparam int unsigned NCHAN  = 3;
  // sum of two squared gradients stays below 2^21
  localparam int unsigned SQ_W      = 21;
  localparam int unsigned ISQ_STEPS = 11;

  localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd480;
  localparam logic [DIM_W-1:0] DIM_MIN    = 11'd3;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_FLUSH = 1'b1;

  // window of one channel: [row][col], row 0 is the oldest line, col 2 the newest pixel
  typedef logic [2:0][2:0][PIX_W-1:0] sgm_win_t;

  typedef struct packed {
    logic load;
    logic square;
    logic step;
  } sgm_lane_ctl_t;

endpackage

// ===== src/sgm_ram.sv =====
module sgm_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/sgm_lane.sv =====
module sgm_lane (
  input  logic                         clk_i,
  input  sgm_pkg::sgm_lane_ctl_t       ctl_i,
  input  sgm_pkg::sgm_win_t            win_i,
  output logic signed [sgm_pkg::GRAD_W-1:0] grad_x_o,
  output logic signed [sgm_pkg::GRAD_W-1:0] grad_y_o,
  output logic [sgm_pkg::MAG_W-1:0]    mag_o
);
  import sgm_pkg::*;

  logic signed [GRAD_W:0] gx_full, gy_full;
  logic signed [GRAD_W-1:0] gx_q, gy_q;
  logic [SQ_W-1:0] v_q, v_d;
  logic [SQ_W:0]   res_q, res_d, bit_q, trial;
  logic [2*GRAD_W-1:0] sqx, sqy;

  always_comb begin
    gx_full = $signed({4'd0, win_i[0][2]}) + $signed({3'd0, win_i[1][2], 1'b0})
            + $signed({4'd0, win_i[2][2]}) - $signed({4'd0, win_i[0][0]})
            - $signed({3'd0, win_i[1][0], 1'b0}) - $signed({4'd0, win_i[2][0]});
    gy_full = $signed({4'd0, win_i[0][0]}) + $signed({3'd0, win_i[0][1], 1'b0})
            + $signed({4'd0, win_i[0][2]}) - $signed({4'd0, win_i[2][0]})
            - $signed({3'd0, win_i[2][1], 1'b0}) - $signed({4'd0, win_i[2][2]});
  end

  assign sqx = (2*GRAD_W)'($signed(gx_q) * $signed(gx_q));
  assign sqy = (2*GRAD_W)'($signed(gy_q) * $signed(gy_q));

  // one digit of the floor square root per step
  always_comb begin
    trial = res_q + bit_q;
    v_d   = v_q;
    res_d = res_q >> 1;
    if ({1'b0, v_q} >= trial) begin
      v_d   = SQ_W'({1'b0, v_q} - trial);
      res_d = (res_q >> 1) + bit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      gx_q <= GRAD_W'(gx_full);
      gy_q <= GRAD_W'(gy_full);
    end
    if (ctl_i.square) begin
      v_q   <= SQ_W'(sqx + sqy);
      res_q <= '0;
      bit_q <= (SQ_W+1)'(1) << (SQ_W-1);
    end else if (ctl_i.step) begin
      v_q   <= v_d;
      res_q <= res_d;
      bit_q <= bit_q >> 2;
    end
  end

  assign grad_x_o = gx_q;
  assign grad_y_o = gy_q;
  assign mag_o    = MAG_W'(res_q);

endmodule

// ===== src/sobel_gradient_magnitude.sv =====
// Three-channel 3x3 Sobel gradient and magnitude over a raster pixel stream.
// Input channel: in_valid_i / in_stall_o with mode_i and chan_0..2_i. A pixel
// word enters the line stores and the window; a flush word drains one pending
// result. Output channel: out_valid_o / out_stall_i, one word per result with
// grad_x, grad_y and mag per channel, its row, column and a frame_end flag.
// Each result describes the pixel image_width+1 pixel words back; border
// pixels and flushed results carry zero gradients.
// A word that yields no result passes the read and update states only; one
// that yields a result goes on through the calculate and done states, where
// the bit-serial row/column divider runs alongside the three per-channel
// iterative square roots, one bit per cycle. One word is in work at a time.
// The finished result sits in an output register; the next word is taken while
// it waits, and only the hand-off into that register waits on out_stall_i.
// Reset clears the window, counters and configuration registers (width 640, height 480);
// the line stores hold garbage until the first two rows have been written.
module sobel_gradient_magnitude #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_index_i,
  input  logic [sgm_pkg::DIM_W-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic mode_i,
  input  logic [sgm_pkg::PIX_W-1:0] chan_0_i,
  input  logic [sgm_pkg::PIX_W-1:0] chan_1_i,
  input  logic [sgm_pkg::PIX_W-1:0] chan_2_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic signed [sgm_pkg::GRAD_W-1:0] grad_x_0_o,
  output logic signed [sgm_pkg::GRAD_W-1:0] grad_x_1_o,
  output logic signed [sgm_pkg::GRAD_W-1:0] grad_x_2_o,
  output logic signed [sgm_pkg::GRAD_W-1:0] grad_y_0_o,
  output logic signed [sgm_pkg::GRAD_W-1:0] grad_y_1_o,
  output logic signed [sgm_pkg::GRAD_W-1:0] grad_y_2_o,
  output logic [sgm_pkg::MAG_W-1:0] mag_0_o,
  output logic [sgm_pkg::MAG_W-1:0] mag_1_o,
  output logic [sgm_pkg::MAG_W-1:0] mag_2_o,
  output logic [sgm_pkg::POS_W-1:0] out_row_o,
  output logic [sgm_pkg::POS_W-1:0] out_col_o,
  output logic frame_end_o
);
  import sgm_pkg::*;

  localparam int unsigned PXW    = NCHAN * PIX_W;
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned MW_EFF = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
  localparam int unsigned MH_EFF = (MAX_HEIGHT < 2047) ? MAX_HEIGHT : 2047;
  localparam int unsigned IDX_W  = $clog2(MW_EFF * MH_EFF);
  localparam int unsigned TOT_W  = 2 * DIM_W;
  localparam int unsigned PEND_W = $clog2(MAX_WIDTH + 3);
  localparam int unsigned NSTEPS = (IDX_W > ISQ_STEPS + 2) ? IDX_W : ISQ_STEPS + 2;
  localparam int unsigned CNT_W  = $clog2(NSTEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic [DIM_W-1:0] width_q, height_q, w_cl, h_cl;
  logic [TOT_W-1:0] total_q;
  logic mode_q;
  logic [PXW-1:0] px_q, up1, up2;
  logic [2:0][2:0][PXW-1:0] win_q;
  logic [COL_W-1:0] col_q;
  logic [PEND_W-1:0] pend_q;
  logic [IDX_W-1:0] oidx_q;
  logic [CNT_W-1:0] cnt_q;
  logic use_win_q, fend_q;
  logic [IDX_W-1:0] quo_q;
  logic [DIM_W-1:0] rem_q;
  logic [DIM_W:0] rem_sh;
  logic emit;
  logic [TOT_W-1:0] idx_cl;
  logic interior;
  logic accept, in_stall;
  sgm_lane_ctl_t lane_ctl;
  logic signed [NCHAN-1:0][GRAD_W-1:0] gx, gy;
  logic [NCHAN-1:0][MAG_W-1:0] mag;
  logic out_valid_q;

  always_comb begin
    w_cl = width_q;
    if (width_q < DIM_MIN) w_cl = DIM_MIN;
    else if (32'(width_q) > MAX_WIDTH) w_cl = DIM_W'(MAX_WIDTH);
    h_cl = height_q;
    if (height_q < DIM_MIN) h_cl = DIM_MIN;
    else if (32'(height_q) > MAX_HEIGHT) h_cl = DIM_W'(MAX_HEIGHT);
  end

  assign in_stall = (state_q != S_IDLE);
  assign in_stall_o = in_stall;
  assign accept = in_valid_i && !in_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      total_q  <= TOT_W'(WIDTH_RST) * TOT_W'(HEIGHT_RST);
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_WIDTH:  width_q  <= cfg_data_i;
          CFG_HEIGHT: height_q <= cfg_data_i;
          default: ;
        endcase
      end
      total_q <= TOT_W'(w_cl) * TOT_W'(h_cl);
    end
  end

  sgm_ram #(.WIDTH(PXW), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk_i, .we_i(state_q == S_UPD && mode_q == MODE_PIXEL), .waddr_i(col_q),
    .wdata_i(px_q), .re_i(accept), .raddr_i(col_q), .rdata_o(up1)
  );

  sgm_ram #(.WIDTH(PXW), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk_i, .we_i(state_q == S_UPD && mode_q == MODE_PIXEL), .waddr_i(col_q),
    .wdata_i(up1), .re_i(accept), .raddr_i(col_q), .rdata_o(up2)
  );

  always_comb begin
    if (mode_q == MODE_FLUSH) emit = (pend_q != '0);
    else emit = (32'(pend_q) > 32'(w_cl));
    idx_cl = (TOT_W'(oidx_q) < total_q) ? TOT_W'(oidx_q) : total_q - 1'b1;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_READ;
      S_READ: state_d = S_UPD;
      S_UPD:  state_d = emit ? S_CALC : S_IDLE;
      S_CALC: if (cnt_q == CNT_W'(NSTEPS - 1)) state_d = S_DONE;
      S_DONE: if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign rem_sh = {rem_q, quo_q[IDX_W-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      win_q   <= '0;
      col_q   <= '0;
      pend_q  <= '0;
      oidx_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_UPD) begin
        cnt_q <= '0;
        if (mode_q == MODE_PIXEL) begin
          for (int k = 0; k < 3; k++) begin
            win_q[k][0] <= win_q[k][1];
            win_q[k][1] <= win_q[k][2];
          end
          win_q[0][2] <= up2;
          win_q[1][2] <= up1;
          win_q[2][2] <= px_q;
          if (32'(col_q) + 32'd1 >= 32'(w_cl)) col_q <= '0;
          else col_q <= col_q + 1'b1;
        end
        if (emit) begin
          if (mode_q == MODE_FLUSH) pend_q <= pend_q - 1'b1;
          if (32'(oidx_q) + 32'd1 >= 32'(total_q)) oidx_q <= '0;
          else oidx_q <= oidx_q + 1'b1;
        end else if (mode_q == MODE_PIXEL) begin
          pend_q <= pend_q + 1'b1;
        end
      end else if (state_q == S_CALC) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // latch the word, then divide the result index by the width one bit a cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      px_q   <= {chan_2_i, chan_1_i, chan_0_i};
    end
    if (state_q == S_UPD) begin
      use_win_q <= (mode_q == MODE_PIXEL);
      fend_q    <= (32'(oidx_q) + 32'd1 >= 32'(total_q));
      quo_q     <= IDX_W'(idx_cl);
      rem_q     <= '0;
    end else if (state_q == S_CALC && 32'(cnt_q) < IDX_W) begin
      if (rem_sh >= {1'b0, w_cl}) begin
        rem_q <= DIM_W'(rem_sh - {1'b0, w_cl});
        quo_q <= {quo_q[IDX_W-2:0], 1'b1};
      end else begin
        rem_q <= DIM_W'(rem_sh);
        quo_q <= {quo_q[IDX_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    lane_ctl.load   = (state_q == S_CALC) && (cnt_q == '0);
    lane_ctl.square = (state_q == S_CALC) && (cnt_q == CNT_W'(1));
    lane_ctl.step   = (state_q == S_CALC) && (32'(cnt_q) >= 32'd2)
                      && (32'(cnt_q) < ISQ_STEPS + 2);
  end

  for (genvar c = 0; c < NCHAN; c++) begin : g_lane
    sgm_win_t win_c;
    for (genvar k = 0; k < 3; k++) begin : g_row
      for (genvar j = 0; j < 3; j++) begin : g_col
        assign win_c[k][j] = win_q[k][j][PIX_W*c +: PIX_W];
      end
    end
    sgm_lane u_lane (
      .clk_i, .ctl_i(lane_ctl), .win_i(win_c),
      .grad_x_o(gx[c]), .grad_y_o(gy[c]), .mag_o(mag[c])
    );
  end

  assign interior = use_win_q && (quo_q != '0) && (32'(quo_q) + 32'd2 <= 32'(h_cl))
                    && (rem_q != '0) && (32'(rem_q) + 32'd2 <= 32'(w_cl));

  // merge the lanes into the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
      grad_x_0_o  <= interior ? gx[0] : '0;
      grad_x_1_o  <= interior ? gx[1] : '0;
      grad_x_2_o  <= interior ? gx[2] : '0;
      grad_y_0_o  <= interior ? gy[0] : '0;
      grad_y_1_o  <= interior ? gy[1] : '0;
      grad_y_2_o  <= interior ? gy[2] : '0;
      mag_0_o     <= interior ? mag[0] : '0;
      mag_1_o     <= interior ? mag[1] : '0;
      mag_2_o     <= interior ? mag[2] : '0;
      out_row_o   <= POS_W'(quo_q);
      out_col_o   <= POS_W'(rem_q);
      frame_end_o <= fend_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(pend_q) <= MAX_WIDTH + 1)
    else $error("pending count beyond line length");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_DONE))
    else $error("result appeared without finished computation");

  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (mag_0_o <= 11'd1442 && mag_1_o <= 11'd1442 && mag_2_o <= 11'd1442))
    else $error("magnitude out of range");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import sgm_pkg::*;

  localparam int MAXW = 1024;
  localparam int MAXH = 1024;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_ITEMS = 250;

  typedef struct packed {
    logic [2:0][GRAD_W-1:0] gx;
    logic [2:0][GRAD_W-1:0] gy;
    logic [2:0][MAG_W-1:0]  mag;
    logic [POS_W-1:0]       row;
    logic [POS_W-1:0]       col;
    logic                   fe;
  } grad_word_t;

  logic clk_i, rst_ni;
  logic cfg_we_i, cfg_index_i;
  logic [DIM_W-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o, mode_i;
  logic [PIX_W-1:0] chan_0_i, chan_1_i, chan_2_i;
  logic out_valid_o, out_stall_i;
  logic signed [GRAD_W-1:0] grad_x_0_o, grad_x_1_o, grad_x_2_o;
  logic signed [GRAD_W-1:0] grad_y_0_o, grad_y_1_o, grad_y_2_o;
  logic [MAG_W-1:0] mag_0_o, mag_1_o, mag_2_o;
  logic [POS_W-1:0] out_row_o, out_col_o;
  logic frame_end_o;

  sobel_gradient_magnitude u_dut (.*);

  // predictor state
  logic [23:0] row_prev [MAXW];
  logic [23:0] row_prev2 [MAXW];
  logic [23:0] win [3][3];
  int col_cnt, row_cnt, res_index, pend;
  logic [DIM_W-1:0] reg_width, reg_height;

  grad_word_t grad_q [$];
  int errors, items_sent, words_checked, frames_run;
  int hold_req;
  bit quiet_sender;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int clamp_dim(logic [DIM_W-1:0] v, int hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic int floor_sqrt(int v);
    int lo, hi, mid;
    lo = 0;
    hi = 2047;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      if (mid * mid <= v) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic int chan_val(logic [23:0] px, int ch);
    return int'(px[8*ch +: 8]);
  endfunction

  function automatic grad_word_t next_grad_word(bit use_win);
    grad_word_t g;
    int w, h, total, idx, orow, ocol, gx, gy, wt;
    bit inner;
    w = clamp_dim(reg_width, MAXW);
    h = clamp_dim(reg_height, MAXH);
    total = w * h;
    idx = (res_index < total) ? res_index : total - 1;
    orow = idx / w;
    ocol = idx % w;
    inner = use_win && orow >= 1 && orow <= h - 2 && ocol >= 1 && ocol <= w - 2;
    for (int ch = 0; ch < 3; ch++) begin
      gx = 0;
      gy = 0;
      if (inner) begin
        for (int k = 0; k < 3; k++) begin
          wt = (k == 1) ? 2 : 1;
          gx += wt * (chan_val(win[k][2], ch) - chan_val(win[k][0], ch));
          gy += wt * (chan_val(win[0][k], ch) - chan_val(win[2][k], ch));
        end
      end
      g.gx[ch] = gx[GRAD_W-1:0];
      g.gy[ch] = gy[GRAD_W-1:0];
      g.mag[ch] = inner ? MAG_W'(floor_sqrt(gx * gx + gy * gy)) : '0;
    end
    g.row = orow[POS_W-1:0];
    g.col = ocol[POS_W-1:0];
    g.fe = (res_index + 1 >= total);
    res_index = (res_index + 1 >= total) ? 0 : res_index + 1;
    if (pend > 0) pend--;
    return g;
  endfunction

  function automatic void predict_word(logic md, logic [23:0] px);
    int w, h, c;
    logic [23:0] up1, up2;
    w = clamp_dim(reg_width, MAXW);
    h = clamp_dim(reg_height, MAXH);
    if (md == MODE_FLUSH) begin
      if (pend > 0) grad_q.push_back(next_grad_word(1'b0));
      return;
    end
    c = (col_cnt < MAXW) ? col_cnt : 0;
    up1 = row_prev[c];
    up2 = row_prev2[c];
    row_prev2[c] = up1;
    row_prev[c] = px;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = px;
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
    pend++;
    if (pend > w + 1) grad_q.push_back(next_grad_word(1'b1));
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    grad_word_t g;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (grad_q.size() == 0) begin
        report("unexpected word", 1, 0);
      end else begin
        g = grad_q.pop_front();
        words_checked++;
        if (grad_x_0_o !== g.gx[0]) report("grad_x_0", grad_x_0_o, $signed(g.gx[0]));
        if (grad_x_1_o !== g.gx[1]) report("grad_x_1", grad_x_1_o, $signed(g.gx[1]));
        if (grad_x_2_o !== g.gx[2]) report("grad_x_2", grad_x_2_o, $signed(g.gx[2]));
        if (grad_y_0_o !== g.gy[0]) report("grad_y_0", grad_y_0_o, $signed(g.gy[0]));
        if (grad_y_1_o !== g.gy[1]) report("grad_y_1", grad_y_1_o, $signed(g.gy[1]));
        if (grad_y_2_o !== g.gy[2]) report("grad_y_2", grad_y_2_o, $signed(g.gy[2]));
        if (mag_0_o !== g.mag[0]) report("mag_0", mag_0_o, g.mag[0]);
        if (mag_1_o !== g.mag[1]) report("mag_1", mag_1_o, g.mag[1]);
        if (mag_2_o !== g.mag[2]) report("mag_2", mag_2_o, g.mag[2]);
        if (out_row_o !== g.row) report("out_row", out_row_o, g.row);
        if (out_col_o !== g.col) report("out_col", out_col_o, g.col);
        if (frame_end_o !== g.fe) report("frame_end", frame_end_o, g.fe);
      end
    end
  end

  // receiver stall pattern
  initial begin
    int r, n;
    out_stall_i = 1'b0;
    forever begin
      if (hold_req > 0) begin
        n = hold_req;
        hold_req = 0;
        out_stall_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 9);
        n = (r < 5) ? $urandom_range(1, 20) : (r < 9) ? $urandom_range(1, 3)
                                                      : $urandom_range(20, 60);
        out_stall_i <= (r >= 5);
      end
      repeat (n) @(posedge clk_i);
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet >= IDLE_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_word(logic md, logic [PIX_W-1:0] c0, logic [PIX_W-1:0] c1,
                           logic [PIX_W-1:0] c2);
    int r, gap;
    r = $urandom_range(0, 19);
    gap = (quiet_sender || r < 12) ? 0 : (r < 18) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 40);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= md;
    chan_0_i <= c0;
    chan_1_i <= c1;
    chan_2_i <= c2;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_word(md, {c2, c1, c0});
    items_sent++;
  endtask

  task automatic send_flush();
    send_word(MODE_FLUSH, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom));
  endtask

  task automatic drain_pending();
    while (pend > 0) send_flush();
  endtask

  // drop valid, then wait for every word and let the block settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (grad_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_dims(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    reg_width = w;
    cfg_index_i <= CFG_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    reg_height = h;
    cfg_we_i <= 1'b0;
  endtask

  // pat 0: random, 1: vertical and horizontal edges; stop after limit pixels
  task automatic send_frame(int pat, int noise, int limit);
    int w, h, n;
    logic [PIX_W-1:0] a, b, c;
    w = clamp_dim(reg_width, MAXW);
    h = clamp_dim(reg_height, MAXH);
    n = 0;
    for (int r = 0; r < h; r++) begin
      for (int k = 0; k < w; k++) begin
        if (n >= limit) return;
        if (pat == 1) begin
          a = (k == 0) ? 8'd0 : 8'd255;
          b = ~a;
          c = (r == 0) ? 8'd255 : 8'd0;
        end else begin
          a = PIX_W'($urandom);
          b = PIX_W'($urandom);
          c = PIX_W'($urandom);
        end
        send_word(MODE_PIXEL, a, b, c);
        if (noise > 0 && $urandom_range(0, noise) == 0) send_flush();
        n++;
      end
    end
    frames_run++;
  endtask

  // full frame at the widest random width; fills every column that the
  // random frames touch in both line stores
  task automatic test_line_fill();
    set_dims(11'd40, 11'd3);
    send_frame(0, 0, 1 << 30);
    drain_pending();
    wait_idle();
  endtask

  // widest frame, clamped from above; too short for a full window, so every
  // word comes out through a flush
  task automatic test_widest_frame();
    set_dims(11'd2047, 11'd0);
    send_frame(0, 0, 64);
    drain_pending();
    send_flush();
    wait_idle();
  endtask

  task automatic test_directed_edges();
    set_dims(11'd0, 11'd1);
    send_frame(1, 0, 1 << 30);
    drain_pending();
    send_flush();
    wait_idle();
    set_dims(11'd3, 11'd3);
    send_frame(1, 0, 1 << 30);
    drain_pending();
    wait_idle();
  endtask

  // tallest frame, clamped from above; the first rows only
  task automatic test_tallest_frame();
    set_dims(11'd3, 11'd2047);
    send_frame(0, 0, 90);
    drain_pending();
    wait_idle();
  endtask

  task automatic test_backpressure();
    set_dims(11'd8, 11'd6);
    quiet_sender = 1'b1;
    hold_req = 300;
    send_frame(0, 0, 1 << 30);
    quiet_sender = 1'b0;
    // hold off until the block has handed back every word
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (grad_q.size() != 0) @(posedge clk_i);
    drain_pending();
    wait_idle();
  endtask

  task automatic test_random_frames();
    int start, r, w, h, nf;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      w = (r < 8) ? $urandom_range(3, 12) : $urandom_range(13, 40);
      h = $urandom_range(3, 7);
      if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 2);
      if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 2);
      set_dims(w[DIM_W-1:0], h[DIM_W-1:0]);
      nf = $urandom_range(1, 3);
      for (int f = 0; f < nf; f++) begin
        r = $urandom_range(0, 9);
        if (r < 7) send_frame(0, 0, 1 << 30);
        else if (r < 9) send_frame(0, 15, 1 << 30);
        else send_frame(0, 0, $urandom_range(1, 40));
        if ($urandom_range(0, 19) == 0) send_flush();
      end
      drain_pending();
      wait_idle();
    end
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    words_checked = 0;
    frames_run = 0;
    hold_req = 0;
    quiet_sender = 1'b0;
    for (int i = 0; i < MAXW; i++) begin
      row_prev[i] = '0;
      row_prev2[i] = '0;
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) win[i][j] = '0;
    col_cnt = 0;
    row_cnt = 0;
    res_index = 0;
    pend = 0;
    reg_width = WIDTH_RST;
    reg_height = HEIGHT_RST;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_WIDTH;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    mode_i = MODE_PIXEL;
    chan_0_i = '0;
    chan_1_i = '0;
    chan_2_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_line_fill();
    test_backpressure();
    test_random_frames();
    test_tallest_frame();
    test_widest_frame();

    wait_idle();
    $display("sent %0d words over %0d frames, checked %0d gradient words",
             items_sent, frames_run, words_checked);
    $display("full frames from 3x3 to 40 wide, partial 1024 wide and tall, flushes, stalls");
    if (errors == 0 && grad_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("errors %0d, words still expected %0d", errors, grad_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
